FILE: design/jmpc_pkg.sv
// Shared types, constants and arithmetic helpers for the MCU-to-pixel converter.
`timescale 1ns / 1ps
`default_nettype none
package jmpc_pkg;

  localparam int unsigned StoreDepth   = 320;
  localparam int unsigned StoreWidth   = 8;
  localparam int unsigned StoreAddrW   = $clog2(StoreDepth);
  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned McuW   = 24;
  localparam int unsigned WidthW = 16;
  localparam int unsigned PrW    = 13;

  localparam logic        RgbReset   = 1'b0;
  localparam logic        FourReset  = 1'b1;
  localparam logic [15:0] WidthReset = 16'd640;

  typedef enum logic [1:0] {
    CFG_RGB   = 2'd0,
    CFG_FOUR  = 2'd1,
    CFG_WIDTH = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                  is_cr;
    logic [2:0]            blk;
    logic [5:0]            pos;
    logic [7:0]            sample;
    logic [McuW-1:0]       mcu;
  } cmd_t;

  // Store address of the luma sample for one pixel of a Cr sample's group.
  function automatic logic [StoreAddrW-1:0] lum_addr(input logic four, input logic [5:0] pos,
                                                     input logic [1:0] pix);
    logic [3:0] px;
    logic [3:0] py;
    logic [2:0] lb;
    px = {pos[2:0], pix[0]};
    py = four ? {pos[5:3], pix[1]} : {1'b0, pos[5:3]};
    lb = four ? {1'b0, py[3], px[3]} : {2'b00, px[3]};
    return StoreAddrW'({lb, py[2:0], px[2:0]});
  endfunction

  // (t / 32, truncating toward zero) + 128, clamped to 0..255.
  function automatic logic [7:0] scale_clamp(input logic signed [15:0] t);
    logic signed [15:0] q;
    logic signed [15:0] s;
    q = (t + (t[15] ? 16'sd31 : 16'sd0)) >>> 5;
    s = q + 16'sd128;
    if (s < 16'sd0) return 8'd0;
    else if (s > 16'sd255) return 8'd255;
    else return s[7:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/jmpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module jmpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 320
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: design/jmpc_front.sv
// Front end: accepts samples, drops unused blocks, queues store and Cr requests.
`timescale 1ns / 1ps
`default_nettype none
module jmpc_front import jmpc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             four_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [McuW-1:0]  mcu_index_i,
  input  wire logic [2:0]       block_index_i,
  input  wire logic [5:0]       position_i,
  input  wire logic [7:0]       sample_i,
  output logic                  q_valid_o,
  output cmd_t                  q_cmd_o,
  input  wire logic             q_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            buf_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            accept, keep, push;
  logic [2:0]      luma_n;
  cmd_t            cmd;

  assign in_stall_o = (cnt_q == CntW'(QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign luma_n     = four_i ? 3'd4 : 3'd2;

  always_comb begin
    cmd.is_cr  = (block_index_i == luma_n + 3'd1);
    cmd.blk    = block_index_i;
    cmd.pos    = position_i;
    cmd.sample = sample_i;
    cmd.mcu    = mcu_index_i;
    keep       = (block_index_i <= luma_n) || cmd.is_cr;
  end

  assign push      = accept && keep;
  assign q_valid_o = (cnt_q != '0);
  assign q_cmd_o   = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rptr_q <= (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !q_pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push && q_pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != '0) else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: design/jmpc_back.sv
// Back end: executes store writes and expands Cr requests into pixels.
`timescale 1ns / 1ps
`default_nettype none
module jmpc_back import jmpc_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   rgb_i,
  input  wire logic                   four_i,
  input  wire logic [WidthW-1:0]      width_i,
  input  wire logic                   q_valid_i,
  input  wire cmd_t                   q_cmd_i,
  output logic                        q_pop_o,
  output logic                        ram_we_o,
  output logic [StoreAddrW-1:0]       ram_waddr_o,
  output logic [StoreWidth-1:0]       ram_wdata_o,
  output logic                        ram_re_o,
  output logic [StoreAddrW-1:0]       ram_raddr_o,
  input  wire logic [StoreWidth-1:0]  ram_rdata_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [15:0]                 pixel_x_o,
  output logic [15:0]                 pixel_y_o,
  output logic [7:0]                  chan0_o,
  output logic [7:0]                  chan1_o,
  output logic [7:0]                  chan2_o,
  output logic                        last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RDCB,
    ST_CBLAT,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [McuW-1:0] mcu_q, last_mcu_q, quo_q, quo_d, my_q;
  logic [PrW-1:0]  rem_q, rem_d, mx_q, last_pr_q, pr;
  logic [13:0]     trial;
  logic [4:0]      cnt_q;
  logic            hit_vld_q, hit;
  logic [5:0]      pos_q;
  logic [7:0]      cr_q, cb_q;
  logic [1:0]      pix_q;
  logic            fin, can_load;
  logic [16:0]     pr_sum;
  logic [3:0]      px_off, py_off;
  logic [15:0]     px, py;
  logic signed [15:0] ys, cbs, crs, r_t, g_t, b_t;
  logic [7:0]      c0, c1, c2;

  assign pr_sum = {1'b0, width_i} + 17'd15;
  assign pr     = (pr_sum[16:4] == '0) ? PrW'(1) : pr_sum[16:4];
  assign hit    = hit_vld_q && (last_mcu_q == q_cmd_i.mcu) && (last_pr_q == pr);

  assign trial = {rem_q, quo_q[McuW-1]};
  always_comb begin
    if (trial >= {1'b0, pr}) begin
      rem_d = PrW'(trial - {1'b0, pr});
      quo_d = {quo_q[McuW-2:0], 1'b1};
    end else begin
      rem_d = trial[PrW-1:0];
      quo_d = {quo_q[McuW-2:0], 1'b0};
    end
  end

  assign can_load = !out_valid_o || !out_stall_i;
  assign fin      = four_i ? (pix_q == 2'd3) : (pix_q == 2'd1);

  assign px_off = {pos_q[2:0], pix_q[0]};
  assign py_off = four_i ? {pos_q[5:3], pix_q[1]} : {1'b0, pos_q[5:3]};
  assign px     = {mx_q[11:0], 4'b0} + {12'b0, px_off};
  assign py     = (four_i ? {my_q[11:0], 4'b0} : {my_q[12:0], 3'b0}) + {12'b0, py_off};

  assign ys  = {{8{ram_rdata_i[7]}}, ram_rdata_i};
  assign cbs = {{8{cb_q[7]}}, cb_q};
  assign crs = {{8{cr_q[7]}}, cr_q};
  assign r_t = (ys <<< 5) + crs * 16'sd45;
  assign g_t = (ys <<< 5) - cbs * 16'sd11 - crs * 16'sd23;
  assign b_t = (ys <<< 5) + cbs * 16'sd57;

  always_comb begin
    if (rgb_i) begin
      c0 = scale_clamp(r_t);
      c1 = scale_clamp(g_t);
      c2 = scale_clamp(b_t);
    end else begin
      c0 = ram_rdata_i ^ 8'h80;
      c1 = cb_q ^ 8'h80;
      c2 = cr_q ^ 8'h80;
    end
  end

  always_comb begin
    q_pop_o     = (state_q == ST_IDLE) && q_valid_i;
    ram_we_o    = q_pop_o && !q_cmd_i.is_cr;
    ram_waddr_o = StoreAddrW'({q_cmd_i.blk, q_cmd_i.pos});
    ram_wdata_o = q_cmd_i.sample;
    ram_re_o    = 1'b0;
    ram_raddr_o = lum_addr(four_i, pos_q, pix_q + 2'd1);
    unique case (state_q)
      ST_RDCB: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = StoreAddrW'({(four_i ? 3'd4 : 3'd2), pos_q});
      end
      ST_CBLAT: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = lum_addr(four_i, pos_q, 2'd0);
      end
      ST_EMIT: begin
        ram_re_o = can_load && !fin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hit_vld_q   <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i && q_cmd_i.is_cr) begin
            mcu_q <= q_cmd_i.mcu;
            pos_q <= q_cmd_i.pos;
            cr_q  <= q_cmd_i.sample;
            rem_q <= '0;
            quo_q <= q_cmd_i.mcu;
            cnt_q <= '0;
            state_q <= hit ? ST_RDCB : ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'(McuW - 1)) begin
            mx_q       <= rem_d;
            my_q       <= quo_d;
            last_mcu_q <= mcu_q;
            last_pr_q  <= pr;
            hit_vld_q  <= 1'b1;
            state_q    <= ST_RDCB;
          end
        end
        ST_RDCB: begin
          state_q <= ST_CBLAT;
        end
        ST_CBLAT: begin
          cb_q    <= ram_rdata_i;
          pix_q   <= 2'd0;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_load) begin
            out_valid_o <= 1'b1;
            pixel_x_o   <= px;
            pixel_y_o   <= py;
            chan0_o     <= c0;
            chan1_o     <= c1;
            chan2_o     <= c2;
            last_o      <= fin;
            pix_q       <= pix_q + 2'd1;
            if (fin) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_EMIT)) else $error("pixel outside emit");
  a_rd_wr_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o)) else $error("store read and write together");
  a_last_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && can_load && fin) |=> state_q == ST_IDLE)
    else $error("group end did not release");

endmodule
`default_nettype wire

FILE: design/jpeg_mcu_to_pixel_converter.sv
// Top level of the MCU-to-pixel converter: configuration registers and the two halves.
`timescale 1ns / 1ps
`default_nettype none
// Luma and Cb samples are queued and written to the block store at one request per
// cycle while the back end is idle. A Cr sample is popped, two store reads follow,
// and its pixels (2 in 4:2:2, 4 in 4:2:0) are then emitted; when its MCU index or the
// MCUs-per-row count differs from the previous Cr sample, a bit-serial divider first
// splits the index into MCU column and row. The result register lets the next request
// be taken while a pixel waits on the output. The store is not cleared after reset.
module jpeg_mcu_to_pixel_converter import jmpc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [McuW-1:0]   mcu_index_i,
  input  wire logic [2:0]        block_index_i,
  input  wire logic [5:0]        position_i,
  input  wire logic signed [7:0] sample_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [15:0]            pixel_x_o,
  output logic [15:0]            pixel_y_o,
  output logic [7:0]             chan0_o,
  output logic [7:0]             chan1_o,
  output logic [7:0]             chan2_o,
  output logic                   last_o
);

  logic              rgb_q, four_q;
  logic [WidthW-1:0] width_q;
  logic              q_valid, q_pop;
  cmd_t              q_cmd;
  logic              we, re;
  logic [StoreAddrW-1:0] waddr, raddr;
  logic [StoreWidth-1:0] wdata, rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_q   <= RgbReset;
      four_q  <= FourReset;
      width_q <= WidthReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RGB:   rgb_q   <= cfg_wdata_i[0];
        CFG_FOUR:  four_q  <= cfg_wdata_i[0];
        CFG_WIDTH: width_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  jmpc_front #(.QueueDepth(QueueDepth)) u_front (
    .clk_i, .rst_ni,
    .four_i        (four_q),
    .in_valid_i, .in_stall_o,
    .mcu_index_i, .block_index_i, .position_i,
    .sample_i      (sample_i),
    .q_valid_o     (q_valid),
    .q_cmd_o       (q_cmd),
    .q_pop_i       (q_pop)
  );

  jmpc_ram #(.Width(StoreWidth), .Depth(StoreDepth)) u_store (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  jmpc_back u_back (
    .clk_i, .rst_ni,
    .rgb_i       (rgb_q),
    .four_i      (four_q),
    .width_i     (width_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .ram_we_o    (we),
    .ram_waddr_o (waddr),
    .ram_wdata_o (wdata),
    .ram_re_o    (re),
    .ram_raddr_o (raddr),
    .ram_rdata_i (rdata),
    .out_valid_o, .out_stall_i,
    .pixel_x_o, .pixel_y_o, .chan0_o, .chan1_o, .chan2_o, .last_o
  );

endmodule
`default_nettype wire
